[src/bcd_pkg.sv]
`timescale 1ns / 1ps
// bcd_pkg: shared types, register codes, reset values and helper functions
// for the block change detector. No dependencies.

package bcd_pkg;

    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    localparam int CHAN_W = 8;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_BLOCK_COLS_DEF = 64;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    localparam logic [CHAN_W-1:0] THRESHOLD_RST = 8'd0;
    localparam logic [DIM_W-1:0] BLOCK_SIZE_RST = 13'd16;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD,
        REG_BLOCK_SIZE,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLR,
        ST_RUN,
        ST_EMIT
    } state_t;

    // size registers are used clamped to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 13'd1;
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

    function automatic logic chan_differs(input logic [CHAN_W-1:0] a,
                                          input logic [CHAN_W-1:0] b,
                                          input logic [CHAN_W-1:0] th);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > th;
    endfunction

endpackage

[src/bcd_ram.sv]
`timescale 1ns / 1ps
// bcd_ram: generic single-write, single-read synchronous RAM with registered
// read data (old data on a same-address collision). No dependencies.

module bcd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/block_change_detector_top.sv]
`timescale 1ns / 1ps
// block_change_detector_top: frame difference change detector, top level.
// Depends on bcd_pkg and bcd_ram.
//
// Usage:
//   s_ channel: one pixel pair per word, previous frame in the low 32 bits
//   and current frame in the high 32 bits; tuser flags the first pixel of a
//   frame. m_ channel: one changed-block rectangle per word, tlast on the
//   last rectangle of a block row. cfg channel: register writes, always ready.
//   Throughput: one pixel per cycle inside a block row. After the last pixel
//   of a block row with at least one changed block, input pauses while the
//   flag memory is scanned up to the highest changed block column, and it
//   also waits while the receiver holds m_tready low. A rectangle leaves
//   once the next changed block or the end of the scan is found. A frame
//   start while flags are still set clears the flag memory up to the
//   highest changed block column (one entry per cycle) before the next
//   pixel is taken. Reset: registers return to defaults, then a clearing
//   pass over all MAX_BLOCK_COLS flag memory entries runs with s_tready low.
//   A stalled receiver holds the output word; the scan waits on it, input is
//   still taken while only the last word of a row waits.

module block_change_detector_top
    import bcd_pkg::*;
#(
    parameter int MAX_BLOCK_COLS = MAX_BLOCK_COLS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // prev_red, prev_green, prev_blue, prev_alpha,
    // curr_red, curr_green, curr_blue, curr_alpha (8 bits each)
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // frame_start
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // block_left[11:0], block_top[23:12], block_right[36:24],
    // block_bottom[49:37], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,   // last_in_row
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
    localparam int CNT_W = COL_W + 1;
    localparam int LEFT_W = COL_W + DIM_W;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_BLOCK_COLS - 1);

    // configuration
    logic [CHAN_W-1:0] thresh_reg;
    logic [DIM_W-1:0]  bs_cfg_reg, w_cfg_reg, h_cfg_reg;
    logic [DIM_W-1:0]  bs, w, h;

    // position state
    logic [POS_W-1:0] col_pos_reg, row_pos_reg, pib_reg, rib_reg, brt_reg;
    logic [COL_W-1:0] bci_reg;

    // flag bookkeeping
    state_t           state_reg, state_next;
    logic             any_reg;
    logic [COL_W-1:0] max_slot_reg;
    logic [COL_W-1:0] clr_addr_reg, clr_end_reg;
    logic             clr_flag_reg, emit_after_reg;

    // emission
    logic [POS_W-1:0]  em_top_reg;
    logic [DIM_W-1:0]  em_bottom_reg, em_bs_reg, em_w_reg;
    logic [CNT_W-1:0]  rd_addr_reg;
    logic [LEFT_W-1:0] iss_left_reg, chk_left_reg;
    logic [COL_W-1:0]  chk_idx_reg;
    logic              chk_valid_reg;
    logic              pend_valid_reg;
    logic [POS_W-1:0]  pend_left_reg;
    logic [DIM_W-1:0]  pend_right_reg;

    // output register
    logic                 m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // ram ports
    logic             wr_en, rd_en;
    logic [COL_W-1:0] wr_addr;
    logic [0:0]       wr_data, rd_data;

    // pixel path
    logic             accept, fs, pix_changed, go_clear;
    logic [POS_W-1:0] cp_b, rp_b, pib_b, rib_b, brt_b;
    logic [COL_W-1:0] bci_b;
    logic [DIM_W-1:0] cp1, rp1, pib1, rib1;
    logic [POS_W-1:0] cp_n, rp_n, pib_n, rib_n, brt_n;
    logic [COL_W-1:0] bci_n;
    logic             blk_end;
    logic [DIM_W-1:0] bottom_n;

    // scan control
    logic             issue, hit, stall, out_free, scan_done;
    logic             push_mid, push_last, emit_enter;
    logic [LEFT_W:0]  right_sum;
    logic [DIM_W-1:0] right_val;

    assign bs = clamp_dim(bs_cfg_reg);
    assign w  = clamp_dim(w_cfg_reg);
    assign h  = clamp_dim(h_cfg_reg);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_RUN);
    assign accept    = s_tvalid && s_tready;
    assign fs        = s_tuser;

    assign pix_changed = chan_differs(s_tdata[7:0],   s_tdata[39:32], thresh_reg)
                      || chan_differs(s_tdata[15:8],  s_tdata[47:40], thresh_reg)
                      || chan_differs(s_tdata[23:16], s_tdata[55:48], thresh_reg)
                      || chan_differs(s_tdata[31:24], s_tdata[63:56], thresh_reg);

    assign go_clear = accept && fs && any_reg;

    // position counters, frame start zeroes them first
    always_comb begin
        cp_b  = fs ? '0 : col_pos_reg;
        rp_b  = fs ? '0 : row_pos_reg;
        pib_b = fs ? '0 : pib_reg;
        rib_b = fs ? '0 : rib_reg;
        brt_b = fs ? '0 : brt_reg;
        bci_b = fs ? '0 : bci_reg;

        cp1  = {1'b0, cp_b} + 13'd1;
        pib1 = {1'b0, pib_b} + 13'd1;
        rp1  = {1'b0, rp_b} + 13'd1;
        rib1 = {1'b0, rib_b} + 13'd1;

        if (pib1 >= bs) begin
            pib_n = '0;
            bci_n = (bci_b != LAST_COL) ? bci_b + COL_W'(1) : bci_b;
        end else begin
            pib_n = pib1[POS_W-1:0];
            bci_n = bci_b;
        end

        cp_n     = cp1[POS_W-1:0];
        rp_n     = rp_b;
        rib_n    = rib_b;
        brt_n    = brt_b;
        blk_end  = 1'b0;
        bottom_n = (rp1 > h) ? h : rp1;
        if (cp1 >= w) begin
            cp_n  = '0;
            pib_n = '0;
            bci_n = '0;
            rp_n  = rp1[POS_W-1:0];
            rib_n = rib1[POS_W-1:0];
            if (rib1 >= bs || rp1 >= h) begin
                blk_end = 1'b1;
                rib_n   = '0;
                rp_n    = (rp1 >= h) ? '0 : rp1[POS_W-1:0];
                brt_n   = rp_n;
            end
        end
    end

    // scan of the flag memory
    assign out_free  = !m_tvalid_reg || m_tready;
    assign hit       = chk_valid_reg && rd_data[0] && (chk_left_reg < LEFT_W'(em_w_reg));
    assign stall     = (state_reg == ST_EMIT) && hit && pend_valid_reg && !out_free;
    assign scan_done = (rd_addr_reg > {1'b0, max_slot_reg}) && !chk_valid_reg;
    assign issue     = (state_reg == ST_EMIT) && !stall
                    && (rd_addr_reg <= {1'b0, max_slot_reg});
    assign push_mid  = (state_reg == ST_EMIT) && hit && pend_valid_reg && out_free;
    assign push_last = (state_reg == ST_EMIT) && scan_done && pend_valid_reg && out_free;

    assign right_sum = {1'b0, chk_left_reg} + (LEFT_W + 1)'(em_bs_reg);
    assign right_val = (right_sum > (LEFT_W + 1)'(em_w_reg) || chk_idx_reg == LAST_COL)
                     ? em_w_reg : right_sum[DIM_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR: begin
                if (clr_addr_reg == clr_end_reg) begin
                    state_next = (emit_after_reg && clr_flag_reg) ? ST_EMIT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (go_clear) begin
                    state_next = ST_CLR;
                end else if (accept && blk_end && (any_reg || pix_changed)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (scan_done && (!pend_valid_reg || out_free)) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = 1'b0;
        rd_en   = issue;
        case (state_reg)
            ST_CLR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                // entry zero takes the flag of the frame start pixel
                wr_data = (clr_addr_reg == '0) ? clr_flag_reg : 1'b0;
            end
            ST_RUN: begin
                wr_en   = accept && pix_changed && !go_clear;
                wr_addr = bci_b;
                wr_data = 1'b1;
            end
            ST_EMIT: begin
                wr_en   = chk_valid_reg && !stall;
                wr_addr = chk_idx_reg;
                wr_data = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign emit_enter = (state_next == ST_EMIT) && (state_reg != ST_EMIT);

    bcd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_flags (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg[COL_W-1:0]),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESHOLD_RST;
            bs_cfg_reg <= BLOCK_SIZE_RST;
            w_cfg_reg  <= FRAME_WIDTH_RST;
            h_cfg_reg  <= FRAME_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_addr))
                REG_THRESHOLD:    thresh_reg <= cfg_data[CHAN_W-1:0];
                REG_BLOCK_SIZE:   bs_cfg_reg <= cfg_data;
                REG_FRAME_WIDTH:  w_cfg_reg  <= cfg_data;
                REG_FRAME_HEIGHT: h_cfg_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            pib_reg        <= '0;
            rib_reg        <= '0;
            brt_reg        <= '0;
            bci_reg        <= '0;
            any_reg        <= 1'b0;
            max_slot_reg   <= '0;
            clr_addr_reg   <= '0;
            clr_end_reg    <= LAST_COL;
            clr_flag_reg   <= 1'b0;
            emit_after_reg <= 1'b0;
            rd_addr_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (accept) begin
                col_pos_reg <= cp_n;
                row_pos_reg <= rp_n;
                pib_reg     <= pib_n;
                rib_reg     <= rib_n;
                brt_reg     <= brt_n;
                bci_reg     <= bci_n;
            end

            if (go_clear) begin
                clr_addr_reg   <= '0;
                clr_end_reg    <= max_slot_reg;
                clr_flag_reg   <= pix_changed;
                emit_after_reg <= blk_end;
            end else if (accept && pix_changed) begin
                any_reg      <= 1'b1;
                max_slot_reg <= (any_reg && max_slot_reg > bci_b) ? max_slot_reg : bci_b;
            end

            if (state_reg == ST_CLR) begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == clr_end_reg) begin
                    any_reg        <= clr_flag_reg;
                    max_slot_reg   <= '0;
                    emit_after_reg <= 1'b0;
                end
            end

            if (emit_enter) begin
                rd_addr_reg    <= '0;
                chk_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end else if (state_reg == ST_EMIT) begin
                if (!stall) begin
                    chk_valid_reg <= issue;
                    if (issue) begin
                        rd_addr_reg <= rd_addr_reg + CNT_W'(1);
                    end
                end
                if (hit && !stall) begin
                    pend_valid_reg <= 1'b1;
                end else if (push_last) begin
                    pend_valid_reg <= 1'b0;
                end
                if (state_next == ST_RUN) begin
                    any_reg      <= 1'b0;
                    max_slot_reg <= '0;
                end
            end

            if (push_mid || push_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept && blk_end) begin
            em_top_reg    <= brt_b;
            em_bottom_reg <= bottom_n;
            em_bs_reg     <= bs;
            em_w_reg      <= w;
        end
        if (emit_enter) begin
            iss_left_reg <= '0;
        end else if (issue) begin
            iss_left_reg <= iss_left_reg + LEFT_W'(em_bs_reg);
        end
        if (state_reg == ST_EMIT && !stall) begin
            chk_idx_reg  <= rd_addr_reg[COL_W-1:0];
            chk_left_reg <= iss_left_reg;
        end
        if (state_reg == ST_EMIT && hit && !stall) begin
            pend_left_reg  <= chk_left_reg[POS_W-1:0];
            pend_right_reg <= right_val;
        end
        if (push_mid || push_last) begin
            m_tdata_reg <= {6'b0, em_bottom_reg, pend_right_reg, em_top_reg, pend_left_reg};
            m_tlast_reg <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[src/bcd_check.sv]
`timescale 1ns / 1ps
// bcd_check: port-level checks for block_change_detector_top, bound to it
// below. Depends on bcd_pkg.

module bcd_check
    import bcd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // a stalled word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_right_gt_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[36:24] > {1'b0, m_tdata[11:0]})
        else $error("block right edge not past left edge");

    // bottom edge is nonzero and at most MAX_DIM
    a_bottom_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[49:37] != '0 && m_tdata[49:37] <= MAX_DIM)
        else $error("block bottom edge out of range");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // the flag memory is being cleared after reset
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

endmodule

bind block_change_detector_top bcd_check u_bcd_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
